[rtl/i2cms_pkg.sv]
// Shared types and codes for the I2C master event sequencer.
// No dependencies; imported by every module of the block.
package i2cms_pkg;

   // Configuration register indexes
   localparam logic [1:0] CSR_ADDRESS_WORD    = 2'd0;
   localparam logic [1:0] CSR_TEN_BIT_MODE    = 2'd1;
   localparam logic [1:0] CSR_READ_DIRECTION  = 2'd2;
   localparam logic [1:0] CSR_TRANSFER_LENGTH = 2'd3;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 16;

   // tx_kind codes
   localparam logic [1:0] TX_NONE   = 2'd0;
   localparam logic [1:0] TX_BUFFER = 2'd1;
   localparam logic [1:0] TX_VALUE  = 2'd2;

   // ack_change codes
   localparam logic [1:0] ACK_KEEP = 2'd0;
   localparam logic [1:0] ACK_ON   = 2'd1;
   localparam logic [1:0] ACK_OFF  = 2'd2;

   localparam logic [7:0] ADDR_MASK  = 8'hFE;
   localparam logic [7:0] COUNT_MAX  = 8'hFF;
   localparam logic [7:0] LENGTH_RST = 8'd1;

   // Data phase, one-hot
   typedef enum logic [2:0] {
      PHASE_IDLE = 3'b001,
      PHASE_SEND = 3'b010,
      PHASE_RECV = 3'b100
   } phase_type;

   typedef struct packed {
      logic [15:0] address_word;
      logic        ten_bit_mode;
      logic        read_direction;
      logic [7:0]  transfer_length;
   } cfg_type;

   typedef struct packed {
      logic       start_sent;
      logic       header_sent;
      logic       address_done;
      logic       is_transmitter;
      logic       tx_empty;
      logic       byte_finished;
      logic       rx_not_empty;
      logic [7:0] rx_byte;
      logic       bus_error;
      logic       ack_failure;
      logic       arbitration_lost;
   } req_type;

   typedef struct packed {
      logic [1:0] tx_kind;
      logic [7:0] tx_value;
      logic       make_start;
      logic       make_stop;
      logic [1:0] ack_change;
      logic       store_rx;
      logic [7:0] rx_data;
      logic [7:0] buffer_index;
      logic       read_complete;
      logic       error_seen;
   } rsp_type;

endpackage

[rtl/i2c_master_event_sequencer.sv]
// I2C master event sequencer, top level: input register, decision logic, result register.
// A status beat is taken into the input register; its result is then held in the result register.
// Throughput: one beat per cycle while the result side does not stall; the decision is one pass through the core logic.
// A stalled result holds the result register and then the input register.
// Reset (synchronous, active high) clears both valid flags, the transfer state
// and the configuration registers (transfer length back to 1).
module i2c_master_event_sequencer (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  i2cms_pkg::req_type                    req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output i2cms_pkg::rsp_type                    rsp_data,
   input  logic                                  csr_write,
   input  logic [i2cms_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [i2cms_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);
   import i2cms_pkg::*;

   logic    in_valid_ff;
   req_type in_data_ff;
   logic    out_valid_ff;
   rsp_type out_data_ff;
   cfg_type cfg;
   rsp_type core_rsp;
   logic    out_free;
   logic    core_fire;
   logic    req_fire;

   // Handshake: input register drains into the result register when it is free
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign core_fire = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_fire  = req_valid && !req_stall;

   i2cms_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg_o     (cfg)
   );

   i2cms_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire_i (core_fire),
      .req_i  (in_data_ff),
      .cfg_i  (cfg),
      .rsp_o  (core_rsp)
   );

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_fire) begin
         in_valid_ff <= 1'b1;
      end else if (core_fire) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_data_ff <= req_data;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (core_fire) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (core_fire) begin
         out_data_ff <= core_rsp;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // a held beat stays in the input register until it moves on
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !core_fire |=> in_valid_ff)
      else $error("input beat lost while waiting");

   // every beat leaving the input register shows up as a result
   a_core_to_out: assert property (@(posedge clock) disable iff (reset)
      core_fire |=> out_valid_ff)
      else $error("processed beat did not reach result register");

   // a new beat is taken only when the input register frees or is empty
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> !in_valid_ff || core_fire)
      else $error("input register overwritten");

endmodule

[rtl/i2cms_csr.sv]
// Configuration registers of the sequencer: address, mode, direction, length.
// Depends on i2cms_pkg.
module i2cms_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write,
   input  logic [i2cms_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [i2cms_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata,
   output i2cms_pkg::cfg_type                    cfg_o
);
   import i2cms_pkg::*;

   cfg_type cfg_ff, cfg_in;

   // Register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_ADDRESS_WORD:    cfg_in.address_word    = csr_wdata;
            CSR_TEN_BIT_MODE:    cfg_in.ten_bit_mode    = csr_wdata[0];
            CSR_READ_DIRECTION:  cfg_in.read_direction  = csr_wdata[0];
            CSR_TRANSFER_LENGTH: cfg_in.transfer_length = csr_wdata[7:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.address_word    <= '0;
         cfg_ff.ten_bit_mode    <= 1'b0;
         cfg_ff.read_direction  <= 1'b0;
         cfg_ff.transfer_length <= LENGTH_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg_o = cfg_ff;

endmodule

[rtl/i2cms_core.sv]
// Transfer state and per-event decision logic of the sequencer.
// Depends on i2cms_pkg; state advances on each beat handed to it.
module i2cms_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               fire_i,
   input  i2cms_pkg::req_type req_i,
   input  i2cms_pkg::cfg_type cfg_i,
   output i2cms_pkg::rsp_type rsp_o
);
   import i2cms_pkg::*;

   logic [7:0] sent_count_ff, sent_count_in;
   logic [7:0] received_count_ff, received_count_in;
   phase_type  phase_ff, phase_in;
   logic       pending_ff, pending_in;

   logic [7:0] hdr;
   logic [7:0] low;
   logic [7:0] len;
   logic [7:0] cnt_old;
   logic [7:0] cnt_nxt;
   logic [8:0] cnt_nxt_plus;
   phase_type  phase_mid;
   logic       any_error;
   rsp_type    r;

   assign hdr          = cfg_i.address_word[15:8];
   assign low          = cfg_i.address_word[7:0] & ADDR_MASK;
   assign len          = cfg_i.transfer_length;
   assign any_error    = req_i.bus_error | req_i.ack_failure | req_i.arbitration_lost;

   // Decision logic for one status snapshot
   always_comb begin
      r                 = '0;
      sent_count_in     = sent_count_ff;
      received_count_in = received_count_ff;
      phase_mid         = phase_ff;
      pending_in        = pending_ff;

      // address phase: start, then header, then address done
      if (req_i.start_sent) begin
         r.tx_kind = TX_VALUE;
         if (cfg_i.ten_bit_mode) begin
            if (cfg_i.read_direction && pending_ff)
               r.tx_value = (hdr & ADDR_MASK) | 8'd1;
            else
               r.tx_value = hdr;
         end else begin
            r.tx_value = low | {7'd0, cfg_i.read_direction};
         end
      end
      if (req_i.header_sent) begin
         r.tx_kind  = TX_VALUE;
         r.tx_value = low;
      end
      if (req_i.address_done) begin
         if (cfg_i.ten_bit_mode && cfg_i.read_direction && !pending_ff) begin
            r.make_start = 1'b1;
            pending_in   = 1'b1;
         end else begin
            phase_mid  = req_i.is_transmitter ? PHASE_SEND : PHASE_RECV;
            pending_in = 1'b0;
         end
      end

      phase_in = phase_mid;

      // byte counter of the active direction, saturating
      cnt_old      = (phase_mid == PHASE_SEND) ? sent_count_ff : received_count_ff;
      cnt_nxt      = (cnt_old < COUNT_MAX) ? cnt_old + 8'd1 : COUNT_MAX;
      cnt_nxt_plus = {1'b0, cnt_nxt} + 9'd1;

      // data phase
      case (phase_mid)
         PHASE_SEND: begin
            if (req_i.tx_empty) begin
               sent_count_in = cnt_nxt;
               if (cnt_old < len) begin
                  r.tx_kind      = TX_BUFFER;
                  r.tx_value     = 8'd0;
                  r.buffer_index = cnt_old;
               end
               if (cnt_nxt >= len && req_i.byte_finished) begin
                  sent_count_in = 8'd0;
                  phase_in      = PHASE_IDLE;
                  r.make_stop   = 1'b1;
               end
            end
         end
         PHASE_RECV: begin
            if (req_i.rx_not_empty) begin
               received_count_in = cnt_nxt;
               if (cnt_old < len) begin
                  r.store_rx     = 1'b1;
                  r.rx_data      = req_i.rx_byte;
                  r.buffer_index = cnt_old;
               end
               if (cnt_nxt >= len) begin
                  r.read_complete   = 1'b1;
                  received_count_in = 8'd0;
                  phase_in          = PHASE_IDLE;
                  r.ack_change      = ACK_ON;
               end else if (cnt_nxt_plus >= {1'b0, len}) begin
                  r.ack_change = ACK_OFF;
                  r.make_stop  = 1'b1;
               end
            end
         end
         default: ;
      endcase

      // error flags reset the transfer
      if (any_error) begin
         if (req_i.bus_error || req_i.ack_failure)
            r.make_stop = 1'b1;
         sent_count_in     = 8'd0;
         received_count_in = 8'd0;
         phase_in          = PHASE_IDLE;
         pending_in        = 1'b0;
         r.read_complete   = 1'b0;
         r.error_seen      = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sent_count_ff     <= 8'd0;
         received_count_ff <= 8'd0;
         phase_ff          <= PHASE_IDLE;
         pending_ff        <= 1'b0;
      end else if (fire_i) begin
         sent_count_ff     <= sent_count_in;
         received_count_ff <= received_count_in;
         phase_ff          <= phase_in;
         pending_ff        <= pending_in;
      end
   end

   assign rsp_o = r;

   // an error beat leaves a clean idle transfer
   a_error_clears: assert property (@(posedge clock) disable iff (reset)
      fire_i && any_error |=> phase_ff == PHASE_IDLE && sent_count_ff == 8'd0
         && received_count_ff == 8'd0 && !pending_ff)
      else $error("error beat did not clear transfer state");

   // read completion returns to idle
   a_complete_idle: assert property (@(posedge clock) disable iff (reset)
      fire_i && r.read_complete |=> phase_ff == PHASE_IDLE && received_count_ff == 8'd0)
      else $error("read completion left data phase active");

   // repeated start request arms the read header
   a_start_pending: assert property (@(posedge clock) disable iff (reset)
      fire_i && r.make_start && !any_error |=> pending_ff)
      else $error("repeated start without pending read header");

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for i2c_master_event_sequencer: drives status beats, predicts every
// result beat and compares field by field. Depends on i2cms_pkg and the block's RTL.
module tb_top;
   import i2cms_pkg::*;

   localparam int HOLDOFF_CYCLES = 80;
   localparam int IDLE_LIMIT     = 2000;
   localparam int DRAIN_CYCLES   = 4;
   localparam int RANDOM_BEATS   = 1000;
   localparam int MAX_REPORTS    = 40;

   // receiver stall patterns
   localparam int STALL_NONE  = 0;
   localparam int STALL_COIN  = 1;
   localparam int STALL_RARE  = 2;
   localparam int STALL_HEAVY = 3;

   logic                       clock     = 1'b0;
   logic                       reset     = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   req_type                    req_data  = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   rsp_type                    rsp_data;
   logic                       csr_write = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata = '0;

   // predictor copy of configuration and transfer state
   logic [15:0] cfg_address    = '0;
   logic        cfg_ten_bit    = 1'b0;
   logic        cfg_read       = 1'b0;
   logic [7:0]  cfg_length     = LENGTH_RST;
   logic [7:0]  sent_cnt       = '0;
   logic [7:0]  recv_cnt       = '0;
   phase_type   xfer_phase     = PHASE_IDLE;
   logic        hdr_read_armed = 1'b0;

   req_type pending_events[$];
   rsp_type expected_actions[$];

   // driver state
   req_type next_beat;
   logic    next_valid;
   int      burst_left = 1;
   int      gap_left   = 0;

   // receiver state
   logic    stall_next;
   int      stall_mode    = STALL_NONE;
   int      mode_left     = 0;
   int      stall_tick    = 0;
   int      holdoff_left  = 0;
   int      holdoff_asked = 0;
   int      holdoff_taken = 0;

   // bookkeeping
   int      idle_cycles = 0;
   int      fail_count  = 0;
   int      beats_in    = 0;
   int      beats_out   = 0;
   int      stim_beats  = 0;
   int      csr_writes  = 0;
   int      n_stops     = 0;
   int      n_reads     = 0;
   int      n_errors    = 0;
   int      n_stores    = 0;

   i2c_master_event_sequencer u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic bit one_in(input int n);
      return $urandom_range(0, n - 1) == 0;
   endfunction

   function automatic logic [7:0] rand_byte();
      logic [31:0] r;
      r = $urandom;
      return r[7:0];
   endfunction

   // Next-state and result for one status snapshot; updates the predictor state.
   function automatic rsp_type sequence_event(input req_type ev);
      rsp_type    r;
      logic [7:0] hdr;
      logic [7:0] low_addr;
      logic [7:0] old_cnt;
      logic [7:0] nxt_cnt;
      r        = '0;
      hdr      = cfg_address[15:8];
      low_addr = cfg_address[7:0] & ADDR_MASK;

      // address phase: header beat wins over start beat
      if (ev.start_sent) begin
         r.tx_kind = TX_VALUE;
         if (cfg_ten_bit)
            r.tx_value = (cfg_read && hdr_read_armed) ? {hdr[7:1], 1'b1} : hdr;
         else
            r.tx_value = {low_addr[7:1], cfg_read};
      end
      if (ev.header_sent) begin
         r.tx_kind  = TX_VALUE;
         r.tx_value = low_addr;
      end
      if (ev.address_done) begin
         if (cfg_ten_bit && cfg_read && !hdr_read_armed) begin
            r.make_start   = 1'b1;
            hdr_read_armed = 1'b1;
         end else begin
            xfer_phase     = ev.is_transmitter ? PHASE_SEND : PHASE_RECV;
            hdr_read_armed = 1'b0;
         end
      end

      // data phase, acting on the same snapshot
      case (xfer_phase)
         PHASE_SEND: if (ev.tx_empty) begin
            old_cnt  = sent_cnt;
            nxt_cnt  = (old_cnt < COUNT_MAX) ? old_cnt + 8'd1 : COUNT_MAX;
            sent_cnt = nxt_cnt;
            if (old_cnt < cfg_length) begin
               r.tx_kind      = TX_BUFFER;
               r.tx_value     = '0;
               r.buffer_index = old_cnt;
            end
            if (nxt_cnt >= cfg_length && ev.byte_finished) begin
               sent_cnt    = '0;
               xfer_phase  = PHASE_IDLE;
               r.make_stop = 1'b1;
            end
         end
         PHASE_RECV: if (ev.rx_not_empty) begin
            old_cnt  = recv_cnt;
            nxt_cnt  = (old_cnt < COUNT_MAX) ? old_cnt + 8'd1 : COUNT_MAX;
            recv_cnt = nxt_cnt;
            if (old_cnt < cfg_length) begin
               r.store_rx     = 1'b1;
               r.rx_data      = ev.rx_byte;
               r.buffer_index = old_cnt;
            end
            if (nxt_cnt >= cfg_length) begin
               r.read_complete = 1'b1;
               recv_cnt        = '0;
               xfer_phase      = PHASE_IDLE;
               r.ack_change    = ACK_ON;
            end else if ({1'b0, nxt_cnt} + 9'd1 >= {1'b0, cfg_length}) begin
               // one byte left: withdraw ack and ask for stop
               r.ack_change = ACK_OFF;
               r.make_stop  = 1'b1;
            end
         end
         default: ;
      endcase

      // any error drops the transfer
      if (ev.bus_error || ev.ack_failure || ev.arbitration_lost) begin
         if (ev.bus_error || ev.ack_failure)
            r.make_stop = 1'b1;
         sent_cnt        = '0;
         recv_cnt        = '0;
         xfer_phase      = PHASE_IDLE;
         hdr_read_armed  = 1'b0;
         r.read_complete = 1'b0;
         r.error_seen    = 1'b1;
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      fail_count++;
      if (fail_count <= MAX_REPORTS)
         $display("[%0t] result %0d: %s = 0x%0h, expected 0x%0h",
                  $time, beats_out, what, got, want);
   endtask

   task automatic check_field(input string what, input logic [7:0] got,
                              input logic [7:0] want);
      if (got !== want)
         report_mismatch(what, int'(got), int'(want));
   endtask

   // Sender: bursts of random length with random gaps; payload held while stalled.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_actions.push_back(sequence_event(req_data));
            beats_in++;
         end
         if (!req_valid || !req_stall) begin
            next_valid = 1'b0;
            next_beat  = req_data;
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_events.size() != 0) begin
               next_beat  = pending_events.pop_front();
               next_valid = 1'b1;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left   = one_in(4) ? 0 : $urandom_range(1, 12);
               end
            end
            req_valid <= next_valid;
            req_data  <= next_beat;
         end
      end
   end

   // Receiver: stall pattern changes at random intervals; long hold-off on request.
   always @(posedge clock) begin
      if (!reset) begin
         stall_tick++;
         stall_next = 1'b0;
         if (holdoff_left > 0) begin
            holdoff_left--;
            stall_next = 1'b1;
         end else if (holdoff_taken != holdoff_asked) begin
            holdoff_taken = holdoff_asked;
            holdoff_left  = HOLDOFF_CYCLES - 1;
            stall_next    = 1'b1;
         end else begin
            if (mode_left == 0) begin
               stall_mode = $urandom_range(STALL_NONE, STALL_HEAVY);
               mode_left  = $urandom_range(8, 60);
            end else begin
               mode_left--;
            end
            case (stall_mode)
               STALL_COIN:  stall_next = one_in(2);
               STALL_RARE:  stall_next = one_in(8);
               STALL_HEAVY: stall_next = (stall_tick % 4) != 0;
               default:     stall_next = 1'b0;
            endcase
         end
         rsp_stall <= stall_next;
      end
   end

   // Result checker
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         beats_out++;
         if (expected_actions.size() == 0) begin
            report_mismatch("result beat with nothing pending", 1, 0);
         end else begin
            want = expected_actions.pop_front();
            check_field("tx_kind",       8'(rsp_data.tx_kind),       8'(want.tx_kind));
            check_field("tx_value",      rsp_data.tx_value,          want.tx_value);
            check_field("make_start",    8'(rsp_data.make_start),    8'(want.make_start));
            check_field("make_stop",     8'(rsp_data.make_stop),     8'(want.make_stop));
            check_field("ack_change",    8'(rsp_data.ack_change),    8'(want.ack_change));
            check_field("store_rx",      8'(rsp_data.store_rx),      8'(want.store_rx));
            check_field("rx_data",       rsp_data.rx_data,           want.rx_data);
            check_field("buffer_index",  rsp_data.buffer_index,      want.buffer_index);
            check_field("read_complete", 8'(rsp_data.read_complete), 8'(want.read_complete));
            check_field("error_seen",    8'(rsp_data.error_seen),    8'(want.error_seen));
         end
         n_stops  += int'(rsp_data.make_stop);
         n_reads  += int'(rsp_data.read_complete);
         n_errors += int'(rsp_data.error_seen);
         n_stores += int'(rsp_data.store_rx);
      end
   end

   // Watchdog: consecutive cycles without any beat or register write
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      while (idle_cycles < IDLE_LIMIT)
         @(posedge clock);
      $display("Verification failed");
      $finish;
   end

   task automatic add_beat(input req_type ev);
      pending_events.push_back(ev);
      stim_beats++;
   endtask

   // Let every queued beat go through and every result come back.
   task automatic wait_idle();
      @(negedge clock);
      while (pending_events.size() != 0 || req_valid || expected_actions.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] index,
                            input logic [CSR_DATA_WIDTH-1:0] value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      case (index)
         CSR_ADDRESS_WORD:    cfg_address = value;
         CSR_TEN_BIT_MODE:    cfg_ten_bit = value[0];
         CSR_READ_DIRECTION:  cfg_read    = value[0];
         CSR_TRANSFER_LENGTH: cfg_length  = value[7:0];
         default: ;
      endcase
      csr_writes++;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   // Writes all four registers; unused upper bits carry junk.
   task automatic apply_config(input logic [15:0] addr, input logic ten, input logic rd,
                               input logic [7:0] len);
      logic [31:0] junk;
      write_csr(CSR_ADDRESS_WORD, addr);
      junk = $urandom;
      junk[0] = ten;
      write_csr(CSR_TEN_BIT_MODE, junk[15:0]);
      junk = $urandom;
      junk[0] = rd;
      write_csr(CSR_READ_DIRECTION, junk[15:0]);
      junk = $urandom;
      junk[7:0] = len;
      write_csr(CSR_TRANSFER_LENGTH, junk[15:0]);
   endtask

   // Flags that never move the transfer state: random content for sequence beats.
   function automatic req_type filler_event();
      req_type ev;
      ev                = '0;
      ev.rx_byte        = rand_byte();
      ev.is_transmitter = one_in(2);
      ev.start_sent     = one_in(8);
      ev.header_sent    = one_in(8);
      return ev;
   endfunction

   function automatic req_type noise_event();
      req_type     ev;
      logic [31:0] r;
      r                   = $urandom;
      ev                  = r[$bits(req_type)-1:0];
      ev.bus_error        = one_in(12);
      ev.ack_failure      = one_in(12);
      ev.arbitration_lost = one_in(12);
      return ev;
   endfunction

   // One transfer for the current settings; a broken one is cut short or hit by an error.
   task automatic queue_transfer(input bit broken);
      req_type seq[$];
      req_type ev;
      int      n_data;
      int      extra;
      int      cut;
      int      i;
      bit      merge;
      bit      to_send;

      ev = filler_event();
      ev.start_sent = 1'b1;
      seq.push_back(ev);
      if (cfg_ten_bit) begin
         ev = filler_event();
         ev.header_sent = 1'b1;
         seq.push_back(ev);
         if (cfg_read) begin
            // header write done, then repeated start for the read header
            ev = filler_event();
            ev.address_done = 1'b1;
            seq.push_back(ev);
            ev = filler_event();
            ev.start_sent = 1'b1;
            seq.push_back(ev);
         end
      end
      to_send = one_in(10) ? cfg_read : !cfg_read;
      ev = filler_event();
      ev.address_done = 1'b1;
      ev.is_transmitter = to_send;
      seq.push_back(ev);

      merge  = one_in(4);
      n_data = (cfg_length == 0) ? 1 : int'(cfg_length);
      extra  = 0;
      if (to_send && (cfg_length == COUNT_MAX || one_in(4)))
         extra = $urandom_range(1, 3);
      for (i = 0; i < n_data + extra; i++) begin
         ev = filler_event();
         if (to_send) begin
            ev.tx_empty     = 1'b1;
            ev.rx_not_empty = one_in(2);
            if (i == n_data + extra - 1)
               ev.byte_finished = 1'b1;
            else if (i + 1 < int'(cfg_length))
               ev.byte_finished = one_in(2);
         end else begin
            ev.rx_not_empty  = 1'b1;
            ev.tx_empty      = one_in(2);
            ev.byte_finished = one_in(2);
         end
         if (i == 0 && merge) begin
            // address and first data flag in one snapshot
            seq[seq.size()-1] = req_type'(seq[seq.size()-1] | ev);
            seq[seq.size()-1].is_transmitter = to_send;
         end else begin
            seq.push_back(ev);
         end
      end

      if (broken) begin
         cut = $urandom_range(0, seq.size() - 1);
         if (one_in(2)) begin
            while (seq.size() > cut + 1)
               seq.delete(seq.size() - 1);
         end else begin
            case ($urandom_range(0, 2))
               0:       seq[cut].bus_error = 1'b1;
               1:       seq[cut].ack_failure = 1'b1;
               default: seq[cut].arbitration_lost = 1'b1;
            endcase
         end
      end
      foreach (seq[k])
         add_beat(seq[k]);
   endtask

   // Stimulus
   initial begin
      req_type     ev;
      logic [31:0] r;
      logic [15:0] addr;
      logic [7:0]  len;
      logic        ten;
      logic        rd;
      int          n_xfers;
      int          phase_no;
      int          directed_beats;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: reset settings, 7-bit write of one byte
      @(negedge clock);
      ev = '0; add_beat(ev);
      ev = '0; ev.start_sent = 1'b1; add_beat(ev);
      ev = '0; ev.start_sent = 1'b1; ev.header_sent = 1'b1; add_beat(ev);
      ev = '0; ev.address_done = 1'b1; ev.is_transmitter = 1'b1; add_beat(ev);
      ev = '0; ev.tx_empty = 1'b1; add_beat(ev);
      // past the last byte: counts on, loads nothing, then stop with byte_finished
      ev = '0; ev.tx_empty = 1'b1; add_beat(ev);
      ev = '0; ev.tx_empty = 1'b1; ev.byte_finished = 1'b1; add_beat(ev);
      ev = '0; ev.address_done = 1'b1; ev.is_transmitter = 1'b1;
      ev.tx_empty = 1'b1; ev.byte_finished = 1'b1; add_beat(ev);
      ev = '1; add_beat(ev);
      wait_idle();

      // directed: 10-bit read of two bytes with repeated start
      apply_config(16'hF6A5, 1'b1, 1'b1, 8'd2);
      @(negedge clock);
      ev = '0; ev.start_sent = 1'b1; add_beat(ev);
      ev = '0; ev.header_sent = 1'b1; add_beat(ev);
      ev = '0; ev.address_done = 1'b1; add_beat(ev);
      ev = '0; ev.start_sent = 1'b1; add_beat(ev);
      ev = '0; ev.address_done = 1'b1; add_beat(ev);
      ev = '0; ev.rx_not_empty = 1'b1; ev.rx_byte = 8'h00; add_beat(ev);
      ev = '0; ev.rx_not_empty = 1'b1; ev.rx_byte = 8'hFF; add_beat(ev);
      ev = '0; ev.bus_error = 1'b1; add_beat(ev);
      ev = '0; ev.ack_failure = 1'b1; add_beat(ev);
      ev = '0; ev.arbitration_lost = 1'b1; add_beat(ev);
      wait_idle();

      // directed: 7-bit read, zero length completes on the first byte
      apply_config(16'hFFFF, 1'b0, 1'b1, 8'd0);
      @(negedge clock);
      ev = '0; ev.start_sent = 1'b1; add_beat(ev);
      ev = '0; ev.header_sent = 1'b1; add_beat(ev);
      ev = '0; ev.address_done = 1'b1; ev.rx_not_empty = 1'b1; ev.rx_byte = 8'h5A; add_beat(ev);
      ev = '0; ev.address_done = 1'b1; ev.rx_not_empty = 1'b1;
      ev.arbitration_lost = 1'b1; add_beat(ev);
      wait_idle();
      directed_beats = stim_beats;

      // random phases; each ends with the sender paused until all results are back
      phase_no = 0;
      while (stim_beats < directed_beats + RANDOM_BEATS) begin
         r    = $urandom;
         addr = r[15:0];
         if (one_in(8))
            addr = one_in(2) ? 16'h0000 : 16'hFFFF;
         ten = one_in(2);
         rd  = one_in(2);
         if (phase_no == 3) begin
            len = COUNT_MAX;
            ten = 1'b1;
            rd  = 1'b1;
         end else if (phase_no == 6) begin
            len = COUNT_MAX;
            ten = 1'b0;
            rd  = 1'b0;
         end else if (one_in(12)) begin
            len = '0;
         end else if (one_in(10)) begin
            len = rand_byte();
         end else begin
            r   = $urandom_range(1, 8);
            len = r[7:0];
         end
         apply_config(addr, ten, rd, len);
         // receiver holds off while the sender keeps offering
         if (phase_no == 1 || phase_no == 4)
            holdoff_asked++;
         @(negedge clock);
         n_xfers = (len > 8'd16) ? 1 : $urandom_range(2, 6);
         repeat (n_xfers) begin
            queue_transfer(one_in(5));
            if (one_in(3))
               repeat ($urandom_range(1, 3)) add_beat(noise_event());
         end
         wait_idle();
         phase_no++;
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Covered %0d status beats and %0d result beats in %0d random phases, %0d writes",
               beats_in, beats_out, phase_no, csr_writes);
      $display("Results held %0d stops, %0d completed reads, %0d error resets, %0d stores",
               n_stops, n_reads, n_errors, n_stores);
      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
